// ----- rtl/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants of the periodic event scheduler
// commands, status codes, the heap slot layout and the controller/datapath
// command bundle; datapath read data comes back as a plain slot, not in bundles
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_SERVE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [63:0] due;
        logic [31:0] period;
        logic [31:0] id;
    } slot_t;

    // true when a is served before b
    function automatic logic goes_first(input slot_t a, input slot_t b);
        logic r;
        if (a.due != b.due) r = a.due < b.due;
        else if (a.id != b.id) r = a.id < b.id;
        else r = a.period < b.period;
        return r;
    endfunction

    typedef enum logic [2:0] {
        DP_NOP,
        DP_RD_POS,   // read slot at pos
        DP_RD_OTHER, // read slot at other index (parent or child)
        DP_WR_POS,   // write hold register at pos
        DP_WR_OTHER  // write other or best slot register at pos
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

endpackage

// ----- rtl/periodic_event_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_event_scheduler_unit: min-heap scheduler of periodic entries
// insert, serve-and-reschedule and clear on a word stream
// ----------------------------------------------------------------------------
// One command word at a time. Clear, a rejected insert, a serve on an empty
// table and an unused command go straight to the result. An insert climbs
// the heap: it reads the parent, compares, moves the parent down while the
// new entry goes first, and writes the entry where it stops. A serve reads
// the root, reschedules it and sifts it down, reading the left child and,
// where present, the right child at each level. The single-port slot memory
// with registered read sets the rate: each heap level costs its reads, a
// compare and a write-back. One result word per command, held until taken.
module periodic_event_scheduler_unit #(
    parameter int MAX_ENTRIES = pes_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[1:0], entry_id[33:2], period[65:34], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // served_id[31:0], status[33:32], zero fill
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    pes_pkg::dp_cmd_t dp_cmd;
    logic [AW-1:0]    dp_addr;
    pes_pkg::slot_t   dp_wdata, dp_rdata;
    logic [31:0]      res_id;
    logic [1:0]       res_status;

    assign m_tdata = {6'd0, res_status, res_id};

    pes_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_id(s_tdata[33:2]), .in_period(s_tdata[65:34]),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .res_id(res_id), .res_status(res_status),
        .dp_cmd(dp_cmd), .dp_addr(dp_addr), .dp_wdata(dp_wdata), .dp_rdata(dp_rdata)
    );

    pes_dp #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_dp (
        .clk(clk), .dp_cmd(dp_cmd), .dp_addr(dp_addr),
        .dp_wdata(dp_wdata), .dp_rdata(dp_rdata)
    );

endmodule

// ----- rtl/pes_ctrl.sv -----
// ----------------------------------------------------------------------------
// pes_ctrl: command sequencer of the scheduler
// walks a heap sift one level at a time using a single-port slot memory
// ----------------------------------------------------------------------------
module pes_ctrl #(
    parameter int MAX_ENTRIES = pes_pkg::MAX_ENTRIES_DEF,
    parameter int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           in_cmd,
    input  logic [31:0]          in_id,
    input  logic [31:0]          in_period,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          res_id,
    output logic [1:0]           res_status,
    // datapath side
    output pes_pkg::dp_cmd_t     dp_cmd,
    output logic [AW-1:0]        dp_addr,
    output pes_pkg::slot_t       dp_wdata,
    input  pes_pkg::slot_t       dp_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_WAIT, S_UP_CMP,
        S_DN_RD0, S_DN_W0, S_DN_RDL, S_DN_WL, S_DN_RDR, S_DN_WR, S_DN_CMP,
        S_WR_OTHER, S_FIN, S_OUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   pos_reg, oth_reg, best_reg;
    pes_pkg::slot_t  hold_reg, oth_slot_reg, best_slot_reg;
    logic            up_reg;
    logic [31:0]     id_reg;
    logic [1:0]      st_reg;

    logic [AW:0] lft, rgt;
    assign lft = {pos_reg, 1'b1};
    assign rgt = lft + 1'b1;

    logic [64:0] due_sum;
    assign due_sum = {1'b0, dp_rdata.due} + {33'd0, dp_rdata.period};

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = (state_reg == S_OUT);
    assign res_id     = id_reg;
    assign res_status = st_reg;

    always_comb
    begin
        dp_cmd.op = pes_pkg::DP_NOP;
        dp_addr   = pos_reg;
        dp_wdata  = hold_reg;
        unique case (state_reg)
            S_IDLE:     dp_addr = '0;
            S_UP_RD:    begin dp_cmd.op = pes_pkg::DP_RD_OTHER; dp_addr = oth_reg; end
            S_DN_RD0:   begin dp_cmd.op = pes_pkg::DP_RD_POS; dp_addr = '0; end
            S_DN_RDL:   begin dp_cmd.op = pes_pkg::DP_RD_OTHER; dp_addr = lft[AW-1:0]; end
            S_DN_RDR:   begin dp_cmd.op = pes_pkg::DP_RD_OTHER; dp_addr = rgt[AW-1:0]; end
            S_WR_OTHER: begin
                dp_cmd.op = pes_pkg::DP_WR_OTHER; dp_addr = pos_reg;
                dp_wdata = up_reg ? oth_slot_reg : best_slot_reg;
            end
            S_FIN:      begin dp_cmd.op = pes_pkg::DP_WR_POS; dp_addr = pos_reg; end
            default:    dp_cmd.op = pes_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            oth_reg       <= '0;
            best_reg      <= '0;
            hold_reg      <= '0;
            oth_slot_reg  <= '0;
            best_slot_reg <= '0;
            up_reg        <= 1'b0;
            id_reg        <= '0;
            st_reg        <= pes_pkg::ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid)
                begin
                    id_reg <= '0;
                    st_reg <= pes_pkg::ST_OK;
                    state_reg <= S_OUT;
                    if (in_cmd == pes_pkg::CMD_CLEAR) count_reg <= '0;
                    else if (in_cmd == pes_pkg::CMD_INSERT)
                    begin
                        if (count_reg >= CW'(MAX_ENTRIES)) st_reg <= pes_pkg::ST_FULL;
                        else
                        begin
                            hold_reg  <= '{due: {32'd0, in_period}, period: in_period,
                                           id: in_id};
                            pos_reg   <= count_reg[AW-1:0];
                            count_reg <= count_reg + 1'b1;
                            up_reg    <= 1'b1;
                            oth_reg   <= AW'((count_reg - 1'b1) >> 1);
                            state_reg <= (count_reg == '0) ? S_FIN : S_UP_RD;
                        end
                    end
                    else if (in_cmd == pes_pkg::CMD_SERVE)
                    begin
                        if (count_reg == '0) st_reg <= pes_pkg::ST_EMPTY;
                        else
                        begin
                            up_reg    <= 1'b0;
                            pos_reg   <= '0;
                            state_reg <= S_DN_RD0;
                        end
                    end
                end
                S_UP_RD:   state_reg <= S_UP_WAIT;
                S_UP_WAIT: begin oth_slot_reg <= dp_rdata; state_reg <= S_UP_CMP; end
                S_UP_CMP:
                    if (pes_pkg::goes_first(hold_reg, oth_slot_reg))
                        state_reg <= S_WR_OTHER;
                    else state_reg <= S_FIN;
                S_DN_RD0:  state_reg <= S_DN_W0;
                S_DN_W0:
                begin
                    id_reg   <= dp_rdata.id;
                    hold_reg <= '{due: due_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF
                                                   : due_sum[63:0],
                                  period: dp_rdata.period, id: dp_rdata.id};
                    state_reg <= S_DN_CMP;
                    best_reg <= '0;
                end
                S_DN_CMP:
                begin
                    best_slot_reg <= hold_reg;
                    best_reg <= pos_reg;
                    state_reg <= (lft < (AW+1)'(count_reg)) ? S_DN_RDL : S_FIN;
                end
                S_DN_RDL:  state_reg <= S_DN_WL;
                S_DN_WL:
                begin
                    if (pes_pkg::goes_first(dp_rdata, best_slot_reg))
                    begin
                        best_slot_reg <= dp_rdata;
                        best_reg <= lft[AW-1:0];
                    end
                    state_reg <= (rgt < (AW+1)'(count_reg)) ? S_DN_RDR : S_DN_WR;
                end
                S_DN_RDR:  state_reg <= S_DN_WR;
                S_DN_WR:
                begin
                    if ((rgt < (AW+1)'(count_reg)) &&
                        pes_pkg::goes_first(dp_rdata, best_slot_reg))
                    begin
                        best_slot_reg <= dp_rdata;
                        best_reg <= rgt[AW-1:0];
                        state_reg <= S_WR_OTHER;
                    end
                    else if (best_reg != pos_reg) state_reg <= S_WR_OTHER;
                    else state_reg <= S_FIN;
                end
                S_WR_OTHER:
                begin
                    if (up_reg)
                    begin
                        pos_reg <= oth_reg;
                        oth_reg <= AW'((oth_reg - 1'b1) >> 1);
                        state_reg <= (oth_reg == '0) ? S_FIN : S_UP_RD;
                    end
                    else
                    begin
                        pos_reg <= best_reg;
                        state_reg <= S_DN_CMP;
                    end
                end
                S_FIN: state_reg <= S_OUT;
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/pes_dp.sv -----
// ----------------------------------------------------------------------------
// pes_dp: slot memory of the heap
// one port, registered read data
// ----------------------------------------------------------------------------
module pes_dp #(
    parameter int MAX_ENTRIES = pes_pkg::MAX_ENTRIES_DEF,
    parameter int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic               clk,
    input  pes_pkg::dp_cmd_t   dp_cmd,
    input  logic [AW-1:0]      dp_addr,
    input  pes_pkg::slot_t     dp_wdata,
    output pes_pkg::slot_t     dp_rdata
);

    pes_pkg::slot_t mem [MAX_ENTRIES];
    pes_pkg::slot_t rdata_reg;

    assign dp_rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == pes_pkg::DP_WR_POS || dp_cmd.op == pes_pkg::DP_WR_OTHER)
            mem[dp_addr] <= dp_wdata;
        else if (dp_cmd.op == pes_pkg::DP_RD_POS || dp_cmd.op == pes_pkg::DP_RD_OTHER)
            rdata_reg <= mem[dp_addr];
    end

endmodule

// ----- rtl/pes_checker.sv -----
// ----------------------------------------------------------------------------
// pes_checker: port-level checks of the scheduler
// handshake and result code sanity
// ----------------------------------------------------------------------------
module pes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");

    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second word taken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] <= pes_pkg::ST_FULL)) else $error("bad status");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33:32] != pes_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("id on failed command");

endmodule

bind periodic_event_scheduler_unit pes_checker u_pes_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- verif/periodic_event_scheduler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_event_scheduler_unit_tb: self-checking bench of the event scheduler
// drives clear, insert, serve and unused command words with random idling
// and backpressure, predicts every result word and checks it field by field
// ----------------------------------------------------------------------------
module periodic_event_scheduler_unit_tb;

    localparam int TABLE_DEPTH = pes_pkg::MAX_ENTRIES_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // expected result: status and served id
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] served_id;
    } sched_result_t;

    // table model and result scoreboard
    class sched_scoreboard;
        pes_pkg::slot_t table_q[$];
        sched_result_t  pending_q[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        // order of service: due time, then id, then period
        function bit served_sooner(pes_pkg::slot_t a, pes_pkg::slot_t b);
            if (a.due != b.due) return a.due < b.due;
            if (a.id != b.id) return a.id < b.id;
            return a.period < b.period;
        endfunction

        // apply one accepted command word to the table and queue its result
        function void note_word(logic [1:0] cmd, logic [31:0] id, logic [31:0] per);
            sched_result_t  r;
            pes_pkg::slot_t s;
            int             best;
            logic [64:0]    sum;
            r.status    = pes_pkg::ST_OK;
            r.served_id = '0;
            case (cmd)
                pes_pkg::CMD_CLEAR: table_q.delete();
                pes_pkg::CMD_INSERT:
                begin
                    if (table_q.size() >= TABLE_DEPTH)
                        r.status = pes_pkg::ST_FULL;
                    else
                    begin
                        s.id     = id;
                        s.period = per;
                        s.due    = {32'd0, per};
                        table_q.push_back(s);
                    end
                end
                pes_pkg::CMD_SERVE:
                begin
                    if (table_q.size() == 0)
                        r.status = pes_pkg::ST_EMPTY;
                    else
                    begin
                        best = 0;
                        for (int i = 1; i < table_q.size(); i++)
                            if (served_sooner(table_q[i], table_q[best]))
                                best = i;
                        r.served_id = table_q[best].id;
                        sum = {1'b0, table_q[best].due} + {33'd0, table_q[best].period};
                        // due time saturates instead of wrapping
                        table_q[best].due = sum[64] ? '1 : sum[63:0];
                    end
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h got %0h", what, want, got);
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(logic [39:0] word);
            sched_result_t r;
            if (pending_q.size() == 0)
            begin
                report("unexpected word", 32'd0, word[31:0]);
                return;
            end
            r = pending_q.pop_front();
            if (word[33:32] !== r.status)
                report("status", {30'd0, r.status}, {30'd0, word[33:32]});
            if (word[31:0] !== r.served_id)
                report("served_id", r.served_id, word[31:0]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // cmd[1:0], entry_id[33:2], period[65:34], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // served_id[31:0], status[33:32], zero fill

    sched_scoreboard sb;
    bit calm;          // no idling on either side while set
    bit hold_request;  // asks the receiver for a long stall

    periodic_event_scheduler_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = calm || ($urandom_range(99) >= 29);
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);

    // offer one command word, with a random idle gap first
    task automatic send_word(logic [1:0] cmd, logic [31:0] id, logic [31:0] per);
        while (!calm && $urandom_range(99) < 29)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, per, id, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(cmd, id, per);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] pick_id();
        return ($urandom_range(1) != 0) ? 32'($urandom_range(15)) : 32'($urandom);
    endfunction

    function automatic logic [31:0] pick_period();
        int k;
        k = $urandom_range(99);
        if (k < 50) return 32'($urandom_range(8, 1));
        if (k < 80) return 32'($urandom);
        if (k < 85) return 32'd0;
        return 32'hFFFF_FFFF - 32'($urandom_range(255));
    endfunction

    // insert n entries then serve m times
    task automatic run_burst(int n, int m);
        for (int i = 0; i < n; i++)
            send_word(pes_pkg::CMD_INSERT, pick_id(), pick_period());
        for (int i = 0; i < m; i++)
            send_word(pes_pkg::CMD_SERVE, $urandom, $urandom);
    endtask

    initial
    begin
        int sent;
        int k;
        bit held;
        bit paused;
        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        held         = 1'b0;
        paused       = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty serve, unused command, field extremes, ties, zero period
        send_word(pes_pkg::CMD_SERVE, 32'd0, 32'd0);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(pes_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(pes_pkg::CMD_INSERT, 32'd0, 32'd1);
        send_word(pes_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(pes_pkg::CMD_INSERT, 32'd9, 32'd0);
        send_word(pes_pkg::CMD_INSERT, 32'd7, 32'd2);
        send_word(pes_pkg::CMD_INSERT, 32'd3, 32'd2);
        send_word(pes_pkg::CMD_INSERT, 32'd3, 32'd1);
        for (int i = 0; i < 9; i++)
            send_word(pes_pkg::CMD_SERVE, 32'd0, 32'd0);
        send_word(pes_pkg::CMD_CLEAR, 32'd0, 32'd0);
        send_word(pes_pkg::CMD_SERVE, 32'd0, 32'd0);

        // random: mostly insert/serve bursts, some full-table runs and noise
        sent = 0;
        while (sent < 700)
        begin
            calm = (sent >= 300 && sent < 400);
            if (sent >= 150 && !held)
            begin
                held         = 1'b1;
                hold_request = 1'b1;  // sender keeps offering during the stall
            end
            if (sent >= 500 && !paused)
            begin
                paused = 1'b1;
                while (sb.pending_q.size() != 0)
                    @(negedge clk);
            end
            k = $urandom_range(99);
            if (k < 70)
            begin
                int n, m;
                n = $urandom_range(12);
                m = $urandom_range(12);
                run_burst(n, m);
                sent += n + m;
            end
            else if (k < 78)
            begin
                // fill past capacity, then serve a few
                run_burst(TABLE_DEPTH + 3, 6);
                sent += TABLE_DEPTH + 9;
            end
            else if (k < 88)
            begin
                send_word(pes_pkg::CMD_CLEAR, $urandom, $urandom);
                sent++;
            end
            else
            begin
                send_word(2'($urandom_range(3)), $urandom, $urandom);
                sent++;
            end
        end
        calm = 1'b0;

        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #50000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pes_pkg.sv
rtl/pes_ctrl.sv
rtl/pes_dp.sv
rtl/periodic_event_scheduler_unit.sv
rtl/pes_checker.sv
verif/periodic_event_scheduler_unit_tb.sv
